FILE: sv/lpf_pkg.sv
package lpf_pkg;

  // Fixed field widths
  localparam int NUM_FIELDS = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int COEF_W     = 48;
  localparam int NOISE_W    = 16;
  localparam int GAIN_W     = 32;
  localparam int LEVEL_W    = 16;

  // Shared multiplier operand and product widths
  localparam int MUL_W  = 20;
  localparam int PROD_W = 2 * MUL_W;

  // log2(10)/20 in Q0.16
  localparam logic signed [MUL_W-1:0] EXP_K = 20'sd10885;

  // Mantissa width: 2^(i/16) in Q1.16, up to 2^17
  localparam int MANT_W = 18;

  typedef logic [NOISE_W-1:0] noise_t;
  typedef logic [GAIN_W-1:0]  gain_t;
  typedef logic [COEF_W-1:0]  coef_t;

  // Request to the shared multiplier
  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  // 2^(i/16) in Q1.16 for i = 0..16
  function automatic logic [MANT_W-1:0] pow2_tab(input logic [4:0] i);
    logic [MANT_W-1:0] v;
    case (i)
      5'd0:    v = 18'd65536;
      5'd1:    v = 18'd68438;
      5'd2:    v = 18'd71468;
      5'd3:    v = 18'd74632;
      5'd4:    v = 18'd77936;
      5'd5:    v = 18'd81386;
      5'd6:    v = 18'd84990;
      5'd7:    v = 18'd88752;
      5'd8:    v = 18'd92682;
      5'd9:    v = 18'd96785;
      5'd10:   v = 18'd101070;
      5'd11:   v = 18'd105545;
      5'd12:   v = 18'd110218;
      5'd13:   v = 18'd115098;
      5'd14:   v = 18'd120194;
      5'd15:   v = 18'd125515;
      5'd16:   v = 18'd131072;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/lpf_mul.sv
module lpf_mul
  import lpf_pkg::*;
(
  input  logic                     clk,
  input  lpf_pkg::mul_req_t        req,
  output logic signed [PROD_W-1:0] prod_r
);

  // Signed multiply, product registered when requested
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= req.a * req.b;
    end
  end

endmodule

FILE: sv/lognormal_path_fade_generator.sv
// Lognormal path fade generator. Each request carries one Q3.12 Gaussian
// sample per path; every path updates its Q8.8 dB level as
// alpha*level + r*noise (rounded, saturated) and reports
// gain * 10^(level/20) as a saturating unsigned Q16.16 amplitude, the power
// of ten taken as a power of two from a 17-entry table with interpolation
// and a shift. Paths are worked one after another through a single shared
// multiplier: each path takes five products plus level write-back, exponent
// capture, mantissa capture and the final shift, and a request runs the
// smaller of NUM_PATHS and four paths. A finished result waits in the
// output register while the next request is already taken. The user must
// write coefficients on the cfg port while the block is idle; the block
// itself does not enforce this. Paths at or beyond NUM_PATHS read zero.
module lognormal_path_fade_generator
  import lpf_pkg::*;
#(
  parameter int NUM_PATHS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0]     cfg_data,
  // input request
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [NOISE_W-1:0]    in_noise_path0,
  input  logic [NOISE_W-1:0]    in_noise_path1,
  input  logic [NOISE_W-1:0]    in_noise_path2,
  input  logic [NOISE_W-1:0]    in_noise_path3,
  // result request
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [GAIN_W-1:0]     out_gain_path0,
  output logic [GAIN_W-1:0]     out_gain_path1,
  output logic [GAIN_W-1:0]     out_gain_path2,
  output logic [GAIN_W-1:0]     out_gain_path3
);

  localparam int NUM_RUN = (NUM_PATHS < NUM_FIELDS) ? NUM_PATHS : NUM_FIELDS;
  localparam int PW      = (NUM_RUN > 1) ? $clog2(NUM_RUN) : 1;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ALV  = 4'd1;  // alpha * level
  localparam logic [3:0] S_RNZ  = 4'd2;  // r * noise
  localparam logic [3:0] S_LVL  = 4'd3;  // round, saturate, store level
  localparam logic [3:0] S_EXP  = 4'd4;  // level * log2(10)/20
  localparam logic [3:0] S_E16  = 4'd5;  // capture exponent
  localparam logic [3:0] S_DIF  = 4'd6;  // table slope * fraction
  localparam logic [3:0] S_MAN  = 4'd7;  // mantissa
  localparam logic [3:0] S_GAN  = 4'd8;  // gain * mantissa
  localparam logic [3:0] S_OUT  = 4'd9;  // shift and saturate
  localparam logic [3:0] S_DONE = 4'd10; // hand over to output register

  logic [3:0]    state_r, state_nxt;
  logic [PW-1:0] path_r, path_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          last_path;

  coef_t                      coeff_r [NUM_RUN];
  logic signed [LEVEL_W-1:0]  level_r [NUM_RUN];
  noise_t                     noise_r [NUM_FIELDS];
  gain_t                      res_r   [NUM_FIELDS];
  gain_t                      out_r   [NUM_FIELDS];

  logic signed [32:0]         ap_r;
  logic signed [21:0]         e16_r;
  logic [MANT_W-1:0]          m_r;

  mul_req_t                   mreq;
  logic signed [PROD_W-1:0]   prod_r;

  // Current path fields
  logic [15:0]                alpha, rsc, gain;
  logic signed [LEVEL_W-1:0]  lvl;
  noise_t                     nz;
  logic [3:0]                 idx;
  logic [11:0]                sub;
  logic [MANT_W-1:0]          tab_lo, tab_hi;
  logic [12:0]                slope;

  // Level update terms
  logic signed [37:0]         lsum;
  logic signed [21:0]         ytr;
  logic signed [LEVEL_W-1:0]  ysat;

  // Final scaling terms
  logic [33:0]                pg;
  logic signed [6:0]          sh;
  logic [6:0]                 rsh;
  logic [38:0]                lwide;
  logic [33:0]                rwide;
  gain_t                      amp;

  assign alpha     = coeff_r[path_r][15:0];
  assign rsc       = coeff_r[path_r][31:16];
  assign gain      = coeff_r[path_r][47:32];
  assign lvl       = level_r[path_r];
  assign nz        = noise_r[path_r];
  assign last_path = (path_r == PW'(NUM_RUN - 1));

  assign idx    = e16_r[15:12];
  assign sub    = e16_r[11:0];
  assign tab_lo = pow2_tab({1'b0, idx});
  assign tab_hi = pow2_tab(5'({1'b0, idx}) + 5'd1);
  assign slope  = 13'(tab_hi - tab_lo);

  // Multiplier operand select
  always_comb begin
    mreq.en = 1'b0;
    mreq.a  = '0;
    mreq.b  = '0;
    case (state_r)
      S_ALV: begin
        mreq.en = 1'b1;
        mreq.a  = MUL_W'($signed({1'b0, alpha}));
        mreq.b  = MUL_W'(lvl);
      end
      S_RNZ: begin
        mreq.en = 1'b1;
        mreq.a  = MUL_W'($signed({1'b0, rsc}));
        mreq.b  = MUL_W'($signed(nz));
      end
      S_EXP: begin
        mreq.en = 1'b1;
        mreq.a  = MUL_W'(lvl);
        mreq.b  = EXP_K;
      end
      S_DIF: begin
        mreq.en = 1'b1;
        mreq.a  = MUL_W'($signed({1'b0, slope}));
        mreq.b  = MUL_W'($signed({1'b0, sub}));
      end
      S_GAN: begin
        mreq.en = 1'b1;
        mreq.a  = MUL_W'($signed({1'b0, gain}));
        mreq.b  = MUL_W'($signed({1'b0, m_r}));
      end
      default: begin
        mreq.en = 1'b0;
      end
    endcase
  end

  lpf_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .prod_r (prod_r)
  );

  // New level: alpha*level + 16*r*noise, round half up, saturate
  always_comb begin
    lsum = 38'(ap_r) + (38'($signed(prod_r[32:0])) <<< 4) + 38'sd32768;
    ytr  = lsum[37:16];
    if (ytr > 22'sd32767) begin
      ysat = 16'sh7FFF;
    end else if (ytr < -22'sd32768) begin
      ysat = -16'sh8000;
    end else begin
      ysat = ytr[15:0];
    end
  end

  // Amplitude: gain*mantissa shifted by integer exponent - 16
  always_comb begin
    pg    = prod_r[33:0];
    sh    = 7'($signed(e16_r[21:16])) - 7'sd16;
    rsh   = 7'(-sh);
    lwide = {5'b0, pg} << sh[2:0];
    rwide = pg >> rsh[5:0];
    if (!sh[6]) begin
      amp = (|lwide[38:32]) ? '1 : lwide[31:0];
    end else begin
      amp = (|rwide[33:32]) ? '1 : rwide[31:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    path_nxt      = path_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_ALV;
          path_nxt  = '0;
        end
      end
      S_ALV:  state_nxt = S_RNZ;
      S_RNZ:  state_nxt = S_LVL;
      S_LVL:  state_nxt = S_EXP;
      S_EXP:  state_nxt = S_E16;
      S_E16:  state_nxt = S_DIF;
      S_DIF:  state_nxt = S_MAN;
      S_MAN:  state_nxt = S_GAN;
      S_GAN:  state_nxt = S_OUT;
      S_OUT: begin
        if (last_path) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ALV;
          path_nxt  = path_r + PW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      path_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      path_r      <= path_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Coefficients and levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RUN; i++) begin
        coeff_r[i] <= '0;
        level_r[i] <= '0;
      end
    end else begin
      if (cfg_we && ({1'b0, cfg_index} < (CFG_IDX_W + 1)'(NUM_RUN))) begin
        coeff_r[cfg_index[PW-1:0]] <= cfg_data;
      end
      if (state_r == S_LVL) begin
        level_r[path_r] <= ysat;
      end
    end
  end

  // Per-path results; paths that never run stay zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
        res_r[i] <= '0;
      end
    end else if (state_r == S_OUT) begin
      res_r[path_r] <= amp;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      noise_r[0] <= in_noise_path0;
      noise_r[1] <= in_noise_path1;
      noise_r[2] <= in_noise_path2;
      noise_r[3] <= in_noise_path3;
    end
    if (state_r == S_RNZ) begin
      ap_r <= prod_r[32:0];
    end
    if (state_r == S_E16) begin
      e16_r <= prod_r[29:8];
    end
    if (state_r == S_MAN) begin
      m_r <= tab_lo + MANT_W'(prod_r[24:12]);
    end
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
        out_r[i] <= res_r[i];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_gain_path0 = out_r[0];
  assign out_gain_path1 = out_r[1];
  assign out_gain_path2 = out_r[2];
  assign out_gain_path3 = out_r[3];

  // Checks
  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result valid without finishing the request");

  a_start_path0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_ALV) && (path_r == '0))
    else $error("accepted request did not start at the first path");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && last_path |=> (state_r == S_DONE))
    else $error("last path did not finish the request");

  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_valid_r && !out_ready |=>
      (state_r == S_DONE) && out_valid_r)
    else $error("pending result overwritten");

endmodule
